/* design/vsa_pkg.sv */
// Shared types and constants for the voice steal allocator.
// Used by vsa_front, vsa_queue, vsa_back and voice_steal_allocator; no dependencies.
`timescale 1ns / 1ps

package vsa_pkg;

    // Table size and derived index widths
    localparam int SLOTS  = 32;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = 5;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result tier codes
    localparam logic [1:0] TIER_IDLE   = 2'd0;
    localparam logic [1:0] TIER_FINITE = 2'd1;
    localparam logic [1:0] TIER_OLDEST = 2'd2;
    localparam logic [1:0] TIER_WRITE  = 2'd3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [IDX_W:0]    cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QPTR_W:0]   qcnt_t;

    // One slot of the voice table
    typedef struct packed {
        logic [31:0] stamp;
        logic        playing;
        logic [15:0] loops;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{stamp: 32'd0, playing: 1'b0, loops: 16'd1};

    // Classified command as it travels through the queue
    typedef struct packed {
        logic        is_write;
        logic        in_range;
        slot_t       slot;
        logic [30:0] time_ms;
        logic [31:0] stamp;
        logic        playing;
        logic [15:0] loops;
    } qitem_t;

endpackage

/* design/vsa_front.sv */
// Front end: takes input items and classifies them into queue entries.
// Depends on vsa_pkg.
`timescale 1ns / 1ps

module vsa_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [4:0]        s_slot,
    input  logic [30:0]       s_time_ms,
    input  logic              s_playing,
    input  logic [15:0]       s_loops,
    output logic              push_valid,
    input  logic              push_ready,
    output vsa_pkg::qitem_t   push_item
);

    logic endless;

    // Endless voices get the top stamp bit so they look newest
    assign endless = (s_time_ms > 31'd1) && (s_loops == 16'd0);

    always_comb begin
        push_item          = '0;
        push_item.is_write = (s_cmd == vsa_pkg::CMD_WRITE);
        push_item.in_range = (32'(s_slot) < 32'(vsa_pkg::SLOTS));
        push_item.slot     = s_slot;
        push_item.time_ms  = s_time_ms;
        push_item.stamp    = {endless, s_time_ms};
        push_item.playing  = s_playing;
        push_item.loops    = s_loops;
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

/* design/vsa_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on vsa_pkg.
`timescale 1ns / 1ps

module vsa_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  vsa_pkg::qitem_t   push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output vsa_pkg::qitem_t   pop_item
);

    vsa_pkg::qitem_t store_reg [vsa_pkg::QDEPTH];
    vsa_pkg::qptr_t  wr_ptr_reg;
    vsa_pkg::qptr_t  rd_ptr_reg;
    vsa_pkg::qcnt_t  count_reg;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != vsa_pkg::qcnt_t'(vsa_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == vsa_pkg::qptr_t'(vsa_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == vsa_pkg::qptr_t'(vsa_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/vsa_back.sv */
// Back end: holds the voice table, runs writes and the allocation scan,
// and drives the result register. Depends on vsa_pkg.
`timescale 1ns / 1ps

module vsa_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  vsa_pkg::qitem_t   pop_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_chosen_slot,
    output logic [1:0]        m_tier
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    vsa_pkg::cnt_t scan_cnt_reg, scan_cnt_next;
    logic [30:0]   job_time_reg, job_time_next;

    // Table storage; valid bits stand in for the reset contents
    vsa_pkg::entry_t       table_mem [vsa_pkg::SLOTS];
    logic [vsa_pkg::SLOTS-1:0] valid_reg;
    logic                  wr_en;
    vsa_pkg::idx_t         wr_addr;
    vsa_pkg::entry_t       wr_data;
    vsa_pkg::idx_t         rd_addr;
    vsa_pkg::entry_t       rd_data_reg;
    logic                  rd_ok_reg;
    logic                  rd_vld_reg;
    vsa_pkg::idx_t         rd_idx_reg;
    vsa_pkg::entry_t       cur;
    logic                  issue;

    // Best candidate per tier
    logic [2:0]            found_reg;
    logic [31:0]           best_stamp_reg [3];
    vsa_pkg::idx_t         best_idx_reg [3];
    logic [2:0]            eligible;
    logic                  start_scan;

    // Result register
    logic                  out_valid_reg;
    vsa_pkg::slot_t        out_slot_reg, out_slot_next;
    logic [1:0]            out_tier_reg, out_tier_next;
    logic                  out_load;
    logic                  out_free;
    vsa_pkg::idx_t         pick;

    assign out_free = !out_valid_reg || m_ready;
    assign issue    = (state_reg == ST_SCAN) &&
                      (scan_cnt_reg != vsa_pkg::cnt_t'(vsa_pkg::SLOTS));
    assign rd_addr  = scan_cnt_reg[vsa_pkg::IDX_W-1:0];

    always_comb begin
        if (found_reg[0]) begin
            pick = best_idx_reg[0];
        end else if (found_reg[1]) begin
            pick = best_idx_reg[1];
        end else begin
            pick = best_idx_reg[2];
        end
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        job_time_next = job_time_reg;
        pop_ready     = 1'b0;
        start_scan    = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = vsa_pkg::RESET_ENTRY;
        out_load      = 1'b0;
        out_slot_next = out_slot_reg;
        out_tier_next = out_tier_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // Take a command only when its result has a place to go
                pop_ready = out_free;
                if (out_free && pop_valid) begin
                    if (pop_item.is_write) begin
                        wr_en         = pop_item.in_range;
                        wr_addr       = vsa_pkg::idx_t'(pop_item.slot);
                        wr_data       = '{stamp: pop_item.stamp, playing: pop_item.playing,
                                          loops: pop_item.loops};
                        out_load      = 1'b1;
                        out_slot_next = pop_item.slot;
                        out_tier_next = vsa_pkg::TIER_WRITE;
                    end else begin
                        start_scan    = 1'b1;
                        scan_cnt_next = '0;
                        job_time_next = pop_item.time_ms;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == vsa_pkg::cnt_t'(vsa_pkg::SLOTS)) begin
                    state_next = ST_FINISH;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                wr_en         = 1'b1;
                wr_addr       = pick;
                wr_data       = '{stamp: {1'b0, job_time_reg}, playing: 1'b0, loops: 16'd1};
                out_load      = 1'b1;
                out_slot_next = vsa_pkg::slot_t'(pick);
                if (found_reg[0]) begin
                    out_tier_next = vsa_pkg::TIER_IDLE;
                end else if (found_reg[1]) begin
                    out_tier_next = vsa_pkg::TIER_FINITE;
                end else begin
                    out_tier_next = vsa_pkg::TIER_OLDEST;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
        rd_ok_reg   <= valid_reg[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // Never-written slots read as their reset contents
    assign cur      = rd_ok_reg ? rd_data_reg : vsa_pkg::RESET_ENTRY;
    assign eligible = {1'b1, (cur.loops != 16'd0), !cur.playing};

    always_ff @(posedge aclk) begin
        for (int t = 0; t < 3; t++) begin
            if (rd_vld_reg && eligible[t] &&
                (!found_reg[t] || (cur.stamp < best_stamp_reg[t]))) begin
                best_stamp_reg[t] <= cur.stamp;
                best_idx_reg[t]   <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_vld_reg   <= issue;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (start_scan) begin
                found_reg <= '0;
            end else if (rd_vld_reg) begin
                found_reg <= found_reg | eligible;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_time_reg <= job_time_next;
        out_slot_reg <= out_slot_next;
        out_tier_reg <= out_tier_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_chosen_slot = out_slot_reg;
    assign m_tier        = out_tier_reg;

    // The catch-all tier has seen every slot by the end of the scan
    a_all_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> found_reg[2])
        else $error("allocation finished without a candidate");

    // A command leaves the queue only when the result register is free
    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |-> (!out_valid_reg || m_ready))
        else $error("command taken while result register is occupied");

    // Finishing an allocation always presents a result next cycle
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |=> out_valid_reg)
        else $error("allocation result not presented");

    // Scan reads stay inside the table and only occur during a scan
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> ($past(state_reg) == ST_SCAN) &&
                       ($past(scan_cnt_reg) < vsa_pkg::cnt_t'(vsa_pkg::SLOTS)))
        else $error("scan read outside the table");

endmodule

/* design/voice_steal_allocator.sv */
// Top level of the voice steal allocator: front end, command queue, back end.
// Depends on vsa_pkg, vsa_front, vsa_queue and vsa_back.
`timescale 1ns / 1ps

//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_cmd s_slot s_time_ms s_playing s_loops
//  m_       out        m_valid / m_ready  m_chosen_slot m_tier
//
//  A write item is applied straight from ST_IDLE; an allocate item runs a scan
//  that reads one table slot per cycle through the single table read port and
//  compares it, then writes the pick in ST_FINISH; no new item is taken meanwhile.
//  Reset (aresetn low, synchronous) empties the queue, drops any pending
//  result and marks every slot as holding its reset contents at once.
//  Up to two items wait in the queue while the back end is busy or the
//  result register is stalled; s_ready drops only when the queue is full.

module voice_steal_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [4:0]  s_slot,
    input  logic [30:0] s_time_ms,
    input  logic        s_playing,
    input  logic [15:0] s_loops,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_chosen_slot,
    output logic [1:0]  m_tier
);

    logic            push_valid;
    logic            push_ready;
    vsa_pkg::qitem_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    vsa_pkg::qitem_t pop_item;

    // Classify the item: endless stamp bit and write range check
    vsa_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_slot     (s_slot),
        .s_time_ms  (s_time_ms),
        .s_playing  (s_playing),
        .s_loops    (s_loops),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Hold classified items while the back end scans or the output stalls
    vsa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Apply writes, run the three-tier oldest-slot scan, drive results
    vsa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chosen_slot (m_chosen_slot),
        .m_tier        (m_tier)
    );

endmodule
